@@ src/ppnd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppnd_pkg
// Shared types, field widths and codes of the pressure pad note detector.
// ----------------------------------------------------------------------------
package ppnd_pkg;

  localparam int PAD_W      = 8;
  localparam int LVL_W      = 12;
  localparam int SMP_W      = 12;
  localparam int LEN_W      = 5;
  localparam int COOL_W     = 16;
  localparam int TIME_W     = 32;
  localparam int EV_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_ON    = 2'd1;
  localparam logic [EV_W-1:0] EV_OFF   = 2'd2;
  localparam logic [EV_W-1:0] EV_PRESS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PAD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOL = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MOD,
    ST_WRITE,
    ST_SUM,
    ST_DIV,
    ST_DECIDE,
    ST_PEAK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [LVL_W-1:0]  thr;
    logic [LEN_W-1:0]  avg_len;
    logic [LEN_W-1:0]  lag;
    logic [COOL_W-1:0] cool;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic query;
    logic div_ld_mod;
    logic div_ld_avg;
    logic div_step;
    logic mod_take;
    logic wr_sample;
    logic sum_ld;
    logic sum_step;
    logic avg_take;
    logic decide;
    logic peak_ld;
    logic peak_step;
    logic peak_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic need_mod;
    logic div_done;
    logic walk_done;
    logic note_on;
    logic out_free;
  } sts_t;

endpackage

@@ src/ppnd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppnd_ctrl
// Sequencer: steps one sample through index fix-up, ring write, sum walk,
// division, event decision, peak walk and result hand-off; queries skip to it.
// ----------------------------------------------------------------------------
module ppnd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppnd_pkg::sts_t sts_i,
  output ppnd_pkg::cmd_t cmd_o
);
  import ppnd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        priority if (sts_i.mode) begin
          cmd_o.query = 1'b1;
          state_d     = ST_OUT;
        end else if (sts_i.need_mod) begin
          cmd_o.div_ld_mod = 1'b1;
          state_d          = ST_MOD;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_MOD: begin
        if (sts_i.div_done) begin
          cmd_o.mod_take = 1'b1;
          state_d        = ST_WRITE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_sample = 1'b1;
        cmd_o.sum_ld    = 1'b1;
        state_d         = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.div_ld_avg = 1'b1;
          state_d          = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.avg_take = 1'b1;
          state_d        = ST_DECIDE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.note_on) begin
          cmd_o.peak_ld = 1'b1;
          state_d       = ST_PEAK;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_PEAK: begin
        cmd_o.peak_step = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.peak_take = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/ppnd_dp.sv @@
// ----------------------------------------------------------------------------
// ppnd_dp
// Datapath: sample ring with valid bits, peak ring, shared walk counter,
// restoring divider, note state and the output register.
// ----------------------------------------------------------------------------
module ppnd_dp #(
  parameter int AVG_DEPTH   = 16,
  parameter int PEAK_DEPTH  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppnd_pkg::cfg_t                cfg_i,
  input  ppnd_pkg::cmd_t                cmd_i,
  output ppnd_pkg::sts_t                sts_o,
  input  logic                          in_mode_i,
  input  logic [ppnd_pkg::SMP_W-1:0]    in_sample_i,
  input  logic [ppnd_pkg::TIME_W-1:0]   in_time_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ppnd_pkg::EV_W-1:0]     out_ev_o,
  output logic [ppnd_pkg::PAD_W-1:0]    out_pad_o,
  output logic [ppnd_pkg::LVL_W-1:0]    out_lvl_o,
  output logic                          out_pressed_o,
  output logic [ppnd_pkg::LVL_W-1:0]    out_avg_o
);
  import ppnd_pkg::*;

  localparam int RING_W = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
  localparam int SUM_W  = RING_W + LEN_W;
  localparam int NMAX   = (AVG_DEPTH < 31) ? AVG_DEPTH : 31;
  localparam int AW     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int PW     = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
  localparam int PCW    = $clog2(PEAK_DEPTH + 1);
  localparam int CW0    = $clog2(AVG_DEPTH + 1);
  localparam int CW1    = (PCW > CW0) ? PCW : CW0;
  localparam int CNTW   = (CW1 > LEN_W) ? CW1 : LEN_W;
  localparam int DCW    = $clog2(SUM_W + 1);
  localparam int LAGW   = 9;

  // captured item
  logic              mode_q;
  logic [RING_W-1:0] smp_q;
  logic [TIME_W-1:0] time_q;

  // rings
  logic [RING_W-1:0]    smem [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] svalid_q;
  logic [RING_W-1:0]    srd_q;
  logic                 srdv_q;
  logic [LVL_W-1:0]     pmem [PEAK_DEPTH];
  logic [LVL_W-1:0]     prd_q;

  // note state
  logic [AW-1:0]     sptr_q, idx_q;
  logic [LVL_W-1:0]  avg_q;
  logic              held_q, timing_q;
  logic [TIME_W-1:0] start_q, hold_q, rel_q;
  logic [PW-1:0]     pptr_q;
  logic [PCW-1:0]    pcnt_q;

  // walk and divider
  logic [CNTW-1:0]  cnt_q, lim_q;
  logic             rd_ok_q;
  logic [SUM_W-1:0] acc_q;
  logic [LVL_W-1:0] best_q;
  logic [SUM_W-1:0] dvd_q;
  logic [LEN_W-1:0] rem_q, dvs_q;
  logic [DCW-1:0]   dcnt_q;

  // result
  logic [EV_W-1:0]  ev_q;
  logic [LVL_W-1:0] lvl_q;
  logic             ov_q;
  logic [EV_W-1:0]  o_ev_q;
  logic [PAD_W-1:0] o_pad_q;
  logic [LVL_W-1:0] o_lvl_q, o_avg_q;
  logic             o_prs_q;

  logic [LEN_W-1:0]  win;
  logic [8:0]        nxt_ptr;
  logic [LEN_W:0]    dtry;
  logic              dge;
  logic              above, note_on, note_off;
  logic [TIME_W-1:0] start_n, hold_n;
  logic [PCW-1:0]    pcnt_n;
  logic [PW-1:0]     pptr_n;
  logic [LAGW-1:0]   lag_eff;
  logic [TIME_W-1:0] cool_end;
  logic              out_free;

  always_comb begin
    if (cfg_i.avg_len == '0) begin
      win = LEN_W'(1);
    end else if (cfg_i.avg_len > LEN_W'(NMAX)) begin
      win = LEN_W'(NMAX);
    end else begin
      win = cfg_i.avg_len;
    end
  end

  assign nxt_ptr = 9'(idx_q) + 9'd1;
  assign dtry    = {rem_q, dvd_q[SUM_W-1]};
  assign dge     = dtry >= {1'b0, dvs_q};

  assign lag_eff  = (9'(cfg_i.lag) > 9'(PEAK_DEPTH)) ? 9'(PEAK_DEPTH) : 9'(cfg_i.lag);
  assign cool_end = rel_q + TIME_W'(cfg_i.cool);

  always_comb begin
    above   = (avg_q > cfg_i.thr) && !held_q;
    start_n = (above && !timing_q) ? time_q : start_q;
    if (above) begin
      hold_n = time_q - start_n;
      pcnt_n = (pcnt_q == PCW'(PEAK_DEPTH)) ? pcnt_q : pcnt_q + PCW'(1);
      pptr_n = (pptr_q == PW'(PEAK_DEPTH - 1)) ? '0 : pptr_q + PW'(1);
    end else if (timing_q) begin
      hold_n = '0;
      pcnt_n = '0;
      pptr_n = '0;
    end else begin
      hold_n = hold_q;
      pcnt_n = pcnt_q;
      pptr_n = pptr_q;
    end
    note_on  = (hold_n > TIME_W'(lag_eff)) && !held_q && (time_q > cool_end);
    note_off = (avg_q < cfg_i.thr) && held_q;
  end

  assign out_free = !ov_q || out_ready_i;

  assign sts_o.mode      = mode_q;
  assign sts_o.need_mod  = 9'(sptr_q) >= 9'(win);
  assign sts_o.div_done  = dcnt_q == DCW'(SUM_W);
  assign sts_o.walk_done = (cnt_q == lim_q) && !rd_ok_q;
  assign sts_o.note_on   = note_on;
  assign sts_o.out_free  = out_free;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_mode_i;
      smp_q  <= RING_W'(in_sample_i);
      time_q <= in_time_i;
    end
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sample) begin
      smem[idx_q] <= smp_q;
    end
    srd_q <= smem[cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svalid_q <= '0;
      srdv_q   <= 1'b0;
    end else begin
      if (cmd_i.wr_sample) begin
        svalid_q[idx_q] <= 1'b1;
      end
      srdv_q <= svalid_q[cnt_q[AW-1:0]];
    end
  end

  // peak ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && above) begin
      pmem[pptr_q] <= avg_q;
    end
    prd_q <= pmem[cnt_q[PW-1:0]];
  end

  // walk, divider and note state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sptr_q   <= '0;
      idx_q    <= '0;
      avg_q    <= '0;
      held_q   <= 1'b0;
      timing_q <= 1'b0;
      start_q  <= '0;
      hold_q   <= '0;
      rel_q    <= '0;
      pptr_q   <= '0;
      pcnt_q   <= '0;
      cnt_q    <= '0;
      lim_q    <= '0;
      rd_ok_q  <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= sptr_q;
      end
      if (cmd_i.mod_take) begin
        idx_q <= AW'(rem_q);
      end
      if (cmd_i.wr_sample) begin
        sptr_q <= (nxt_ptr >= 9'(win)) ? '0 : AW'(nxt_ptr);
      end

      if (cmd_i.div_ld_mod || cmd_i.div_ld_avg) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step && !sts_o.div_done) begin
        dcnt_q <= dcnt_q + DCW'(1);
      end

      if (cmd_i.sum_ld) begin
        cnt_q   <= '0;
        lim_q   <= CNTW'(win);
        rd_ok_q <= 1'b0;
      end else if (cmd_i.peak_ld) begin
        cnt_q   <= '0;
        lim_q   <= CNTW'(pcnt_n);
        rd_ok_q <= 1'b0;
      end else if (cmd_i.sum_step || cmd_i.peak_step) begin
        if (cnt_q < lim_q) begin
          cnt_q   <= cnt_q + CNTW'(1);
          rd_ok_q <= 1'b1;
        end else begin
          rd_ok_q <= 1'b0;
        end
      end

      if (cmd_i.avg_take) begin
        avg_q <= LVL_W'(dvd_q);
      end

      if (cmd_i.decide) begin
        timing_q <= above;
        start_q  <= start_n;
        hold_q   <= hold_n;
        pcnt_q   <= pcnt_n;
        pptr_q   <= pptr_n;
        held_q   <= note_on || (held_q && !note_off);
        if (note_off) begin
          rel_q <= time_q;
        end
      end
    end
  end

  // divider, accumulator, peak and result datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld_mod) begin
      dvd_q <= SUM_W'(sptr_q);
      rem_q <= '0;
      dvs_q <= win;
    end else if (cmd_i.div_ld_avg) begin
      dvd_q <= acc_q;
      rem_q <= '0;
      dvs_q <= win;
    end else if (cmd_i.div_step && !sts_o.div_done) begin
      rem_q <= dge ? LEN_W'(dtry - {1'b0, dvs_q}) : LEN_W'(dtry);
      dvd_q <= {dvd_q[SUM_W-2:0], dge};
    end

    if (cmd_i.sum_ld) begin
      acc_q <= '0;
    end else if (cmd_i.sum_step && rd_ok_q && srdv_q) begin
      acc_q <= acc_q + SUM_W'(srd_q);
    end

    if (cmd_i.peak_ld) begin
      best_q <= '0;
    end else if (cmd_i.peak_step && rd_ok_q && (prd_q > best_q)) begin
      best_q <= prd_q;
    end

    if (cmd_i.query) begin
      ev_q  <= held_q ? EV_PRESS : EV_NONE;
      lvl_q <= held_q ? avg_q : '0;
    end else if (cmd_i.decide) begin
      ev_q  <= note_off ? EV_OFF : (note_on ? EV_ON : EV_NONE);
      lvl_q <= '0;
    end else if (cmd_i.peak_take) begin
      lvl_q <= best_q;
    end

    if (cmd_i.out_load) begin
      o_ev_q  <= ev_q;
      o_pad_q <= cfg_i.pad;
      o_lvl_q <= lvl_q;
      o_prs_q <= held_q;
      o_avg_q <= avg_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_ev_o      = o_ev_q;
  assign out_pad_o     = o_pad_q;
  assign out_lvl_o     = o_lvl_q;
  assign out_pressed_o = o_prs_q;
  assign out_avg_o     = o_avg_q;

endmodule

@@ src/pressure_pad_note_detector_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_pad_note_detector_unit
// Pressure pad note detector: moving average, hold timing, velocity peak,
// note on / note off / pressure events for one pad.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per item. tuser = mode (0 sample, 1 pressure query),
//           tdata = sample [11:0], time_ms [43:12].
//   m_axis: one beat per item. tuser = event code, tdata = pad [7:0],
//           level [19:8], pressed [20], average [32:21].
//   cfg:    cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
//           write only while no item is in flight.
// Steps, per item, until the result sits in the output register:
//   query:  straight to the output stage.
//   sample: pointer modulo when a shrunk window forces it, ring write,
//           sum walk over the sample ring, bit-serial division by the
//           averaging window n, event decision and, on a note on, a
//           walk over the peak ring.
// One item is processed at a time; a new item is taken while the previous
// result waits. A stalled m_axis holds the result and blocks only the next
// hand-off. Reset clears the sample ring valid bits and all note state and
// sets the configuration to its defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pressure_pad_note_detector_unit #(
  parameter int AVG_DEPTH   = 16,
  parameter int PEAK_DEPTH  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // sample, time_ms
  input  logic                              s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // pad, level, pressed, average
  output logic [ppnd_pkg::EV_W-1:0]         m_axis_tuser,  // event_res
  input  logic                              cfg_we_i,
  input  logic [ppnd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ppnd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import ppnd_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  logic [EV_W-1:0]  out_ev;
  logic [PAD_W-1:0] out_pad;
  logic [LVL_W-1:0] out_lvl, out_avg;
  logic             out_prs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pad     <= '0;
      cfg_q.thr     <= '0;
      cfg_q.avg_len <= LEN_W'(1);
      cfg_q.lag     <= '0;
      cfg_q.cool    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAD:  cfg_q.pad     <= cfg_wdata_i[PAD_W-1:0];
        REG_THR:  cfg_q.thr     <= cfg_wdata_i[LVL_W-1:0];
        REG_LEN:  cfg_q.avg_len <= cfg_wdata_i[LEN_W-1:0];
        REG_LAG:  cfg_q.lag     <= cfg_wdata_i[LEN_W-1:0];
        REG_COOL: cfg_q.cool    <= cfg_wdata_i[COOL_W-1:0];
        default:  cfg_q         <= cfg_q;
      endcase
    end
  end

  ppnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppnd_dp #(
    .AVG_DEPTH   (AVG_DEPTH),
    .PEAK_DEPTH  (PEAK_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_mode_i     (s_axis_tuser),
    .in_sample_i   (s_axis_tdata[11:0]),
    .in_time_i     (s_axis_tdata[43:12]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_ev_o      (out_ev),
    .out_pad_o     (out_pad),
    .out_lvl_o     (out_lvl),
    .out_pressed_o (out_prs),
    .out_avg_o     (out_avg)
  );

  assign m_axis_tuser = out_ev;
  assign m_axis_tdata = {7'd0, out_avg, out_prs, out_lvl, out_pad};

endmodule

@@ sim/note_event_checker.sv @@
// ----------------------------------------------------------------------------
// note_event_checker
// Watches the pad sample stream, the config port and the event stream of the
// pressure pad note detector. Keeps its own copy of the pad state, predicts
// the event beat for every accepted sample or query beat and compares each
// event beat, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module note_event_checker #(
  parameter int AVG_DEPTH  = 16,
  parameter int PEAK_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [47:0]                     s_axis_tdata,  // sample, time_ms
  input  logic                            s_axis_tuser,  // mode
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [39:0]                     m_axis_tdata,  // pad, level, pressed, average
  input  logic [ppnd_pkg::EV_W-1:0]       m_axis_tuser,  // event_res
  input  logic                            cfg_we_i,
  input  logic [ppnd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppnd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppnd_pkg::*;

  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [PAD_W-1:0] pad;
    logic [LVL_W-1:0] level;
    logic             pressed;
    logic [LVL_W-1:0] avg;
  } pad_event_t;

  logic [PAD_W-1:0]  pad_r;
  logic [LVL_W-1:0]  thr_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  lag_r;
  logic [COOL_W-1:0] cool_r;

  logic [SMP_W-1:0]  smp_ring [AVG_DEPTH];
  int unsigned       smp_ptr;
  logic [LVL_W-1:0]  avg_q;
  logic              held_q;
  logic              timing_q;
  logic [TIME_W-1:0] start_t;
  logic [TIME_W-1:0] hold_t;
  logic [TIME_W-1:0] release_t;
  logic [LVL_W-1:0]  peak_ring [PEAK_DEPTH];
  int unsigned       peak_ptr;
  int unsigned       peak_cnt;

  pad_event_t pending_events [$];
  pad_event_t got_ev;
  pad_event_t want_ev;
  int         fails;

  function automatic pad_event_t predict_note_event(input logic query,
                                                    input logic [SMP_W-1:0] smp,
                                                    input logic [TIME_W-1:0] now);
    pad_event_t  r;
    int unsigned win;
    int unsigned lag;
    int unsigned idx;
    int unsigned sum;
    r = '0;
    r.ev = EV_NONE;
    if (query) begin
      if (held_q) begin
        r.ev = EV_PRESS;
        r.level = avg_q;
      end
    end else begin
      win = (len_r < 1) ? 1 : (len_r > AVG_DEPTH) ? AVG_DEPTH : len_r;
      lag = (lag_r > PEAK_DEPTH) ? PEAK_DEPTH : lag_r;
      idx = smp_ptr % win;
      smp_ring[idx] = smp;
      smp_ptr = (idx + 1 >= win) ? 0 : idx + 1;
      sum = 0;
      for (int i = 0; i < win; i++) sum += smp_ring[i];
      avg_q = LVL_W'(sum / win);

      if (avg_q > thr_r && !held_q) begin
        if (!timing_q) begin
          timing_q = 1'b1;
          start_t = now;
        end
        hold_t = now - start_t;
        peak_ring[peak_ptr % PEAK_DEPTH] = avg_q;
        peak_ptr = (peak_ptr + 1) % PEAK_DEPTH;
        if (peak_cnt < PEAK_DEPTH) peak_cnt++;
      end else if (timing_q) begin
        hold_t = '0;
        timing_q = 1'b0;
        peak_cnt = 0;
        peak_ptr = 0;
      end

      // cooldown is a plain unsigned compare against a wrapped sum
      if (hold_t > lag && !held_q && now > TIME_W'(release_t + cool_r)) begin
        r.ev = EV_ON;
        r.level = '0;
        for (int i = 0; i < peak_cnt; i++)
          if (peak_ring[i] > r.level) r.level = peak_ring[i];
        held_q = 1'b1;
      end

      if (avg_q < thr_r && held_q) begin
        r.ev = EV_OFF;
        r.level = '0;
        release_t = now;
        held_q = 1'b0;
      end
    end
    r.pad = pad_r;
    r.pressed = held_q;
    r.avg = avg_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_r = '0;
      thr_r = '0;
      len_r = LEN_W'(1);
      lag_r = '0;
      cool_r = '0;
      for (int i = 0; i < AVG_DEPTH; i++) smp_ring[i] = '0;
      for (int i = 0; i < PEAK_DEPTH; i++) peak_ring[i] = '0;
      smp_ptr = 0;
      avg_q = '0;
      held_q = 1'b0;
      timing_q = 1'b0;
      start_t = '0;
      hold_t = '0;
      release_t = '0;
      peak_ptr = 0;
      peak_cnt = 0;
      pending_events.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PAD:  pad_r = cfg_wdata_i[PAD_W-1:0];
          REG_THR:  thr_r = cfg_wdata_i[LVL_W-1:0];
          REG_LEN:  len_r = cfg_wdata_i[LEN_W-1:0];
          REG_LAG:  lag_r = cfg_wdata_i[LEN_W-1:0];
          REG_COOL: cool_r = cfg_wdata_i[COOL_W-1:0];
          default: ;
        endcase
      end

      // result of the previous item leaves before the next one is queued
      if (m_axis_tvalid && m_axis_tready) begin
        got_ev.ev = m_axis_tuser;
        got_ev.pad = m_axis_tdata[0 +: PAD_W];
        got_ev.level = m_axis_tdata[PAD_W +: LVL_W];
        got_ev.pressed = m_axis_tdata[PAD_W + LVL_W];
        got_ev.avg = m_axis_tdata[PAD_W + LVL_W + 1 +: LVL_W];
        if (pending_events.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t unexpected event beat: ev=%0d pad=%0d level=%0d pressed=%0b avg=%0d",
                     $realtime, got_ev.ev, got_ev.pad, got_ev.level, got_ev.pressed,
                     got_ev.avg);
        end else begin
          want_ev = pending_events.pop_front();
          if (got_ev !== want_ev) begin
            fails++;
            if (fails <= 10)
              $display({"%0t event mismatch: exp ev=%0d pad=%0d level=%0d pressed=%0b",
                        " avg=%0d, got ev=%0d pad=%0d level=%0d pressed=%0b avg=%0d"},
                       $realtime, want_ev.ev, want_ev.pad, want_ev.level, want_ev.pressed,
                       want_ev.avg, got_ev.ev, got_ev.pad, got_ev.level, got_ev.pressed,
                       got_ev.avg);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        pending_events.push_back(predict_note_event(s_axis_tuser,
                                                    s_axis_tdata[0 +: SMP_W],
                                                    s_axis_tdata[SMP_W +: TIME_W]));

      pending_o <= pending_events.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for pressure_pad_note_detector_unit. A short directed
// run over reset settings and a small window, then press and release gestures
// with random content mixed with noise under several register settings and
// sender / receiver idling patterns. Checking is done by note_event_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppnd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_WAIT       = 200;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 72;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;
  logic [EV_W-1:0]       m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int                fail_count;
  int                pending;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                items_sent = 0;
  int                idle_cycles = 0;
  logic [LVL_W-1:0]  cur_thr = '0;
  logic [TIME_W-1:0] now_ms = '0;

  always #5 clk = ~clk;

  pressure_pad_note_detector_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  note_event_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_pad_item(input logic query, input logic [SMP_W-1:0] smp,
                               input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= query;
    s_tdata <= 48'({t, smp});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_pad(input logic [PAD_W-1:0] pad, input logic [LVL_W-1:0] thr,
                             input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] lag,
                             input logic [COOL_W-1:0] cool);
    write_reg(REG_PAD, CFG_DATA_W'(pad));
    write_reg(REG_THR, CFG_DATA_W'(thr));
    write_reg(REG_LEN, CFG_DATA_W'(len));
    write_reg(REG_LAG, CFG_DATA_W'(lag));
    write_reg(REG_COOL, CFG_DATA_W'(cool));
    cfg_we <= 1'b0;
    cur_thr = thr;
  endtask

  task automatic wait_events_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic advance_clock_ms();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) now_ms = $urandom();
    else if (r < 4) now_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    else now_ms = now_ms + $urandom_range(0, 3);
  endtask

  function automatic logic [SMP_W-1:0] above_level();
    if (cur_thr == '1) return '1;
    return SMP_W'(cur_thr + 1 + $urandom_range(0, 4094 - cur_thr));
  endfunction

  function automatic logic [SMP_W-1:0] below_level();
    if (cur_thr == '0) return '0;
    return SMP_W'($urandom_range(0, cur_thr - 1));
  endfunction

  // press held for a while with queries mixed in, then a release; a few
  // stray samples break the sequence on purpose
  task automatic press_and_release();
    int press_n;
    int release_n;
    press_n = $urandom_range(1, 24);
    release_n = $urandom_range(1, 20);
    repeat (press_n) begin
      if ($urandom_range(99) < 15) begin
        send_pad_item(1'b1, SMP_W'($urandom()), $urandom());
      end else begin
        advance_clock_ms();
        send_pad_item(1'b0, ($urandom_range(99) < 8) ? below_level() : above_level(), now_ms);
      end
    end
    repeat (release_n) begin
      if ($urandom_range(99) < 15) begin
        send_pad_item(1'b1, SMP_W'($urandom()), $urandom());
      end else begin
        advance_clock_ms();
        send_pad_item(1'b0, ($urandom_range(99) < 8) ? above_level() : below_level(), now_ms);
      end
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      advance_clock_ms();
      send_pad_item(1'($urandom_range(1)), SMP_W'($urandom()), now_ms);
    end
  endtask

  initial begin
    int goal;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold 0, window 1, no lag, no cooldown
    send_pad_item(1'b1, 12'hFFF, 32'h0);
    send_pad_item(1'b0, 12'h000, 32'h0);
    send_pad_item(1'b0, 12'hFFF, 32'h0);
    send_pad_item(1'b0, 12'hFFF, 32'hFFFF_FFFF);
    send_pad_item(1'b1, 12'h000, 32'hFFFF_FFFF);
    wait_events_drained();

    // window 2, lag 2, cooldown 5: note off, note on, cooldown block,
    // hold timer across the time wrap
    program_pad(8'h3C, 12'd100, 5'd2, 5'd2, 16'd5);
    send_pad_item(1'b0, 12'd0, 32'd5);
    send_pad_item(1'b0, 12'd0, 32'd5);
    send_pad_item(1'b0, 12'hFFF, 32'd10);
    send_pad_item(1'b0, 12'hFFF, 32'd11);
    send_pad_item(1'b0, 12'hFFF, 32'd12);
    send_pad_item(1'b0, 12'hFFF, 32'd13);
    send_pad_item(1'b1, 12'd0, 32'd13);
    send_pad_item(1'b0, 12'd0, 32'd14);
    send_pad_item(1'b0, 12'd0, 32'd15);
    send_pad_item(1'b0, 12'hFFF, 32'd16);
    send_pad_item(1'b0, 12'hFFF, 32'd18);
    send_pad_item(1'b0, 12'hFFF, 32'd19);
    send_pad_item(1'b0, 12'hFFF, 32'd21);
    send_pad_item(1'b0, 12'd0, 32'd22);
    send_pad_item(1'b0, 12'd0, 32'd23);
    send_pad_item(1'b0, 12'hFFF, 32'hFFFF_FFFF);
    send_pad_item(1'b0, 12'hFFF, 32'd0);
    send_pad_item(1'b0, 12'hFFF, 32'd1);
    send_pad_item(1'b0, 12'hFFF, 32'd100);
    send_pad_item(1'b1, 12'hABC, 32'd100);
    wait_events_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: program_pad(8'hFF, 12'd2048, 5'd16, 5'd16, 16'hFFFF);
        1: program_pad(8'h00, 12'd0, 5'd0, 5'd0, 16'd0);
        2: program_pad(8'hA5, 12'hFFF, 5'd31, 5'd31, 16'd1);
        default: program_pad(PAD_W'($urandom_range(0, 255)),
                             LVL_W'($urandom_range(200, 3900)),
                             LEN_W'($urandom_range(0, 31)),
                             LEN_W'($urandom_range(0, 31)),
                             COOL_W'($urandom_range(0, 40)));
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 80) press_and_release();
        else noise_burst();
      end
      wait_events_drained();
    end

    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
